// ===== rtl/uesc_pkg.sv =====
// Shared types, constants and UTF-8 helper functions for the unicode escape decoder.
// No dependencies; imported by uesc_ctrl, uesc_dp and unicode_escape_to_utf8_core.
package uesc_pkg;

  // Escape characters
  localparam logic [7:0] CharBslash = 8'h5C;  // backslash
  localparam logic [7:0] CharLowU   = 8'h75;  // 'u'
  localparam logic [7:0] CharUpU    = 8'h55;  // 'U'

  // Hold buffer: backslash, u/U and up to seven digits
  localparam int unsigned HoldDepth = 9;
  localparam int unsigned CntW      = $clog2(HoldDepth + 1);

  // Held count at which the next digit completes a short / long escape
  localparam logic [CntW-1:0] ShortDone = CntW'(5);
  localparam logic [CntW-1:0] LongDone  = CntW'(9);

  localparam int unsigned AccW = 32;
  localparam int unsigned CpW  = 21;
  localparam int unsigned LenW = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_FLUSH_BRK,
    ST_FLUSH_END,
    ST_CODE
  } state_e;

  typedef enum logic [1:0] {
    ACC_KEEP,
    ACC_CLEAR,
    ACC_SHIFT
  } acc_op_e;

  typedef enum logic [1:0] {
    SRC_BYTE,
    SRC_HELD,
    SRC_CODE,
    SRC_MARK
  } emit_src_e;

  // Controller to datapath
  typedef struct packed {
    logic      latch;
    logic      hold;
    logic      cnt_clr;
    acc_op_e   acc_op;
    logic      idx_clr;
    logic      idx_inc;
    logic      emit;
    emit_src_e emit_src;
    logic      run_last;
    logic      string_end;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_bslash;
    logic is_u;
    logic is_hex;
    logic cnt_zero;
    logic cnt_one;
    logic esc_done;
    logic held_idx_last;
    logic code_none;
    logic code_idx_last;
    logic last;
    logic out_free;
  } dp_sts_t;

  // Hex digit test and value
  function automatic logic is_hex_digit(input logic [7:0] b);
    is_hex_digit = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
                   (b >= 8'h41 && b <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [7:0] v;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = b - 8'h30;
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = b - 8'h57;
    end else begin
      v = b - 8'h37;
    end
    hex_value = v[3:0];
  endfunction

  // Number of UTF-8 bytes for a code point; 0 for surrogates and out of range
  function automatic logic [LenW-1:0] cp_byte_count(input logic [AccW-1:0] cp);
    if (cp >= 32'h0011_0000 || (cp >= 32'h0000_D800 && cp <= 32'h0000_DFFF)) begin
      cp_byte_count = 3'd0;
    end else if (cp < 32'h0000_0080) begin
      cp_byte_count = 3'd1;
    end else if (cp < 32'h0000_0800) begin
      cp_byte_count = 3'd2;
    end else if (cp < 32'h0001_0000) begin
      cp_byte_count = 3'd3;
    end else begin
      cp_byte_count = 3'd4;
    end
  endfunction

  // Byte k of the UTF-8 encoding of cp, given its length
  function automatic logic [7:0] utf8_byte(input logic [CpW-1:0] cp,
                                           input logic [LenW-1:0] len,
                                           input logic [1:0] k);
    logic [7:0] b;
    b = 8'h00;
    unique case (len)
      3'd1: b = {1'b0, cp[6:0]};
      3'd2: b = (k == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      3'd3: begin
        unique case (k)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      3'd4: begin
        unique case (k)
          2'd0: b = {5'b11110, cp[20:18]};
          2'd1: b = {2'b10, cp[17:12]};
          2'd2: b = {2'b10, cp[11:6]};
          2'd3: b = {2'b10, cp[5:0]};
        endcase
      end
      default: b = 8'h00;
    endcase
    utf8_byte = b;
  endfunction

endpackage

// ===== rtl/uesc_dp.sv =====
// Datapath of the unicode escape decoder: input latch, hold buffer, digit accumulator,
// read index and output word register. Uses uesc_pkg; driven by uesc_ctrl.
module uesc_dp
  import uesc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_cmd_t    cmd_i,
  output dp_sts_t    sts_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       run_last_o,
  output logic       string_end_o
);

  logic [7:0]      byte_q;
  logic            last_q;
  logic [7:0]      held_q [HoldDepth];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q;
  logic            byte_valid_q, run_last_q, string_end_q;

  logic [LenW-1:0] code_len;
  logic [7:0]      emit_byte;
  logic            emit_bv;
  logic            long_esc;

  // Latched input word
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      byte_q <= in_byte_i;
      last_q <= in_last_i;
    end
  end

  // Hold buffer, written at the fill position
  always_ff @(posedge clk_i) begin
    if (cmd_i.hold) begin
      held_q[cnt_q] <= byte_q;
    end
  end

  // Count, accumulator and index next state
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.hold) begin
      cnt_d = cnt_q + CntW'(1);
    end
    unique case (cmd_i.acc_op)
      ACC_CLEAR: acc_d = '0;
      ACC_SHIFT: acc_d = {acc_q[AccW-5:0], hex_value(byte_q)};
      default:   acc_d = acc_q;
    endcase
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      acc_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      acc_q <= acc_d;
      idx_q <= idx_d;
    end
  end

  // Output word selection
  assign code_len = cp_byte_count(acc_q);

  always_comb begin
    emit_bv = 1'b1;
    unique case (cmd_i.emit_src)
      SRC_BYTE: emit_byte = byte_q;
      SRC_HELD: emit_byte = held_q[idx_q];
      SRC_CODE: emit_byte = utf8_byte(acc_q[CpW-1:0], code_len, idx_q[1:0]);
      default: begin
        emit_byte = 8'h00;
        emit_bv   = 1'b0;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_byte_q   <= emit_byte;
      byte_valid_q <= emit_bv;
      run_last_q   <= cmd_i.run_last;
      string_end_q <= cmd_i.string_end;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign byte_valid_o = byte_valid_q;
  assign run_last_o   = run_last_q;
  assign string_end_o = string_end_q;

  // Status to the controller
  assign long_esc = (held_q[1] == CharUpU);

  always_comb begin
    sts_o.is_bslash     = (byte_q == CharBslash);
    sts_o.is_u          = (byte_q == CharLowU) || (byte_q == CharUpU);
    sts_o.is_hex        = is_hex_digit(byte_q);
    sts_o.cnt_zero      = (cnt_q == '0);
    sts_o.cnt_one       = (cnt_q == CntW'(1));
    sts_o.esc_done      = long_esc ? (cnt_q >= LongDone) : (cnt_q >= ShortDone);
    sts_o.held_idx_last = ((idx_q + CntW'(1)) == cnt_q);
    sts_o.code_none     = (code_len == '0);
    sts_o.code_idx_last = (idx_q == {1'b0, code_len - LenW'(1)});
    sts_o.last          = last_q;
    sts_o.out_free      = !out_valid_q || out_ready_i;
  end

endmodule

// ===== rtl/uesc_ctrl.sv =====
// Controller of the unicode escape decoder: sequences accept, evaluation, flushes
// and code emission. Uses uesc_pkg; commands uesc_dp.
module uesc_ctrl
  import uesc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_EVAL;
        end
      end

      ST_EVAL: begin
        cmd_o.idx_clr = 1'b1;
        priority if (sts_i.cnt_zero) begin
          if (sts_i.is_bslash) begin
            // start of a possible escape
            cmd_o.hold   = 1'b1;
            cmd_o.acc_op = ACC_CLEAR;
            state_d      = sts_i.last ? ST_FLUSH_END : ST_IDLE;
          end else if (sts_i.out_free) begin
            // plain word passes through
            cmd_o.emit       = 1'b1;
            cmd_o.emit_src   = SRC_BYTE;
            cmd_o.run_last   = 1'b1;
            cmd_o.string_end = sts_i.last;
            state_d          = ST_IDLE;
          end
        end else if (sts_i.cnt_one) begin
          if (sts_i.is_u) begin
            cmd_o.hold = 1'b1;
            state_d    = sts_i.last ? ST_FLUSH_END : ST_IDLE;
          end else begin
            state_d = ST_FLUSH_BRK;
          end
        end else if (sts_i.is_hex) begin
          cmd_o.acc_op = ACC_SHIFT;
          if (sts_i.esc_done) begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = ST_CODE;
          end else begin
            cmd_o.hold = 1'b1;
            state_d    = sts_i.last ? ST_FLUSH_END : ST_IDLE;
          end
        end else begin
          state_d = ST_FLUSH_BRK;
        end
      end

      // Broken escape: emit held words, then handle the breaking word afresh
      ST_FLUSH_BRK: begin
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_src = SRC_HELD;
          cmd_o.run_last = sts_i.held_idx_last && sts_i.is_bslash && !sts_i.last;
          if (sts_i.held_idx_last) begin
            cmd_o.cnt_clr = 1'b1;
            cmd_o.acc_op  = ACC_CLEAR;
            cmd_o.idx_clr = 1'b1;
            state_d       = ST_EVAL;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end

      // End of string: emit whatever is still held
      ST_FLUSH_END: begin
        if (sts_i.out_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_src   = SRC_HELD;
          cmd_o.run_last   = sts_i.held_idx_last;
          cmd_o.string_end = sts_i.held_idx_last;
          if (sts_i.held_idx_last) begin
            cmd_o.cnt_clr = 1'b1;
            cmd_o.acc_op  = ACC_CLEAR;
            state_d       = ST_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end

      // Completed escape: emit its UTF-8 encoding; if invalid, nothing, or only an end marker at string end
      ST_CODE: begin
        if (sts_i.code_none) begin
          if (!sts_i.last) begin
            cmd_o.acc_op = ACC_CLEAR;
            state_d      = ST_IDLE;
          end else if (sts_i.out_free) begin
            cmd_o.emit       = 1'b1;
            cmd_o.emit_src   = SRC_MARK;
            cmd_o.run_last   = 1'b1;
            cmd_o.string_end = 1'b1;
            cmd_o.acc_op     = ACC_CLEAR;
            state_d          = ST_IDLE;
          end
        end else if (sts_i.out_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_src   = SRC_CODE;
          cmd_o.run_last   = sts_i.code_idx_last;
          cmd_o.string_end = sts_i.code_idx_last && sts_i.last;
          if (sts_i.code_idx_last) begin
            cmd_o.acc_op = ACC_CLEAR;
            state_d      = ST_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/unicode_escape_to_utf8_core.sv =====
// Unicode escape decoder top level: one input word at a time, results through an output register.
// Sequence: accept, evaluation, then emission of each output word in turn (a broken escape
// adds a second evaluation). A held word needs accept and evaluation only.
// The controller's single evaluate/emit sequence takes no new word until the last one is through.
// Reset (rst_ni low, asynchronous) clears the held count, accumulator and output valid.
// Uses uesc_pkg, uesc_ctrl and uesc_dp.
module unicode_escape_to_utf8_core
  import uesc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       run_last_o,
  output logic       string_end_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  uesc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  uesc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o)
  );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for unicode_escape_to_utf8_core: escape and plain byte streams in,
// UTF-8 words out, compared against a behavioural decoder kept in step with accepted words.
// Depends on rtl/uesc_pkg.sv and the core RTL only.
`timescale 1ns / 100ps

module tb_top
  import uesc_pkg::*;
();

  localparam int unsigned ClkPeriod = 20;
  localparam int unsigned MaxCycles = 400000;
  localparam int unsigned HoldOffCycles = 300;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       data_valid;
    logic       run_last;
    logic       string_end;
  } out_word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid_o;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       run_last_o;
  logic       string_end_o;

  // Stimulus and scoreboard storage
  in_word_t  bytes_to_send[$];
  out_word_t utf8_expected[$];
  out_word_t step_words[$];
  in_word_t  next_word;
  out_word_t want_word;

  // Decoder state mirrored from the block
  logic [7:0]  held_q[HoldDepth];
  int unsigned held_n = 0;
  logic [31:0] code_acc = '0;

  int tx_idle_pct = 34;
  int rx_idle_pct = 65;
  int tb_phase = 1;
  int n_errors = 0;
  logic rx_hold = 1'b0;

  unicode_escape_to_utf8_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte),
    .in_last_i    (in_last),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Value of a hex digit, -1 if the byte is not one
  function automatic int hex_nibble(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;  // 0..9
    if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h57;  // a..f
    if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h37;  // A..F
    return -1;
  endfunction

  // Hex digit for a nibble, letters in random case
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  function automatic logic [31:0] pick_code_point();
    logic [31:0] cp;
    case ($urandom_range(5))
      0: cp = $urandom_range('h7F);
      1: cp = $urandom_range('h7FF, 'h80);
      2: cp = $urandom_range('hFFFF, 'h800);
      3: cp = $urandom_range('h10FFFF, 'h10000);
      4: cp = $urandom_range('hDFFF, 'hD800);
      default: begin
        cp = $urandom;
        if (cp < 'h110000) cp = cp + 'h110000;
      end
    endcase
    return cp;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Behavioural decoder
  // ---------------------------------------------------------------------------
  task automatic emit_word(input logic [7:0] b);
    step_words.push_back('{data: b, data_valid: 1'b1, run_last: 1'b0, string_end: 1'b0});
  endtask

  // A backslash opens a possible escape, anything else passes through
  task automatic take_fresh(input logic [7:0] b);
    if (b == CharBslash) begin
      held_q[0] = b;
      held_n = 1;
      code_acc = '0;
    end else begin
      emit_word(b);
    end
  endtask

  task automatic release_held();
    for (int i = 0; i < held_n && i < HoldDepth; i++) emit_word(held_q[i]);
    held_n = 0;
    code_acc = '0;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last);
    int nib;
    int unsigned need;
    logic [31:0] cp;
    step_words.delete();
    if (held_n == 0 || held_n > HoldDepth) begin
      held_n = 0;
      take_fresh(b);
    end else if (held_n == 1) begin
      if (b == CharLowU || b == CharUpU) begin
        held_q[1] = b;
        held_n = 2;
      end else begin
        release_held();
        take_fresh(b);
      end
    end else begin
      need = (held_q[1] == CharUpU) ? 8 : 4;
      nib = hex_nibble(b);
      if (nib >= 0) begin
        code_acc = (code_acc << 4) | 32'(nib);
        if (held_n + 1 >= 2 + need) begin
          cp = code_acc;
          // encode; surrogates and values beyond the last plane are dropped
          if (cp < 'h110000 && !(cp >= 'hD800 && cp <= 'hDFFF)) begin
            if (cp < 'h80) begin
              emit_word(cp[7:0]);
            end else if (cp < 'h800) begin
              emit_word({3'b110, cp[10:6]});
              emit_word({2'b10, cp[5:0]});
            end else if (cp < 'h10000) begin
              emit_word({4'b1110, cp[15:12]});
              emit_word({2'b10, cp[11:6]});
              emit_word({2'b10, cp[5:0]});
            end else begin
              emit_word({5'b11110, cp[20:18]});
              emit_word({2'b10, cp[17:12]});
              emit_word({2'b10, cp[11:6]});
              emit_word({2'b10, cp[5:0]});
            end
          end
          held_n = 0;
          code_acc = '0;
        end else begin
          held_q[held_n] = b;
          held_n++;
        end
      end else begin
        release_held();
        take_fresh(b);
      end
    end
    if (last) begin
      release_held();
      // nothing left to say: a lone end marker
      if (step_words.size() == 0) step_words.push_back('0);
      step_words[step_words.size() - 1].string_end = 1'b1;
    end
    if (step_words.size() != 0) step_words[step_words.size() - 1].run_last = 1'b1;
    foreach (step_words[i]) utf8_expected.push_back(step_words[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input logic last);
    bytes_to_send.push_back('{data: b, last: last});
  endtask

  task automatic end_string();
    bytes_to_send[bytes_to_send.size() - 1].last = 1'b1;
  endtask

  // Backslash, u or U, then the leading n_digits digits of the escape
  task automatic push_escape(input logic [31:0] cp, input bit long_form, input int n_digits);
    int width;
    width = long_form ? 8 : 4;
    push_byte(CharBslash, 1'b0);
    push_byte(long_form ? CharUpU : CharLowU, 1'b0);
    for (int i = 0; i < n_digits; i++) push_byte(hex_char(cp[4 * (width - 1 - i) +: 4]), 1'b0);
  endtask

  // Mostly well-formed escapes, with broken escapes and raw bytes mixed in
  task automatic fill_random(input int n_bytes);
    int start;
    int pick;
    logic [31:0] cp;
    bit long_form;
    logic [7:0] b;
    start = bytes_to_send.size();
    while (bytes_to_send.size() - start < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        cp = pick_code_point();
        long_form = (cp > 'hFFFF) || ($urandom_range(3) == 0);
        push_escape(cp, long_form, long_form ? 8 : 4);
      end else if (pick < 75) begin
        if ($urandom_range(3) == 0) begin
          push_byte(CharBslash, 1'b0);
        end else begin
          long_form = 1'($urandom_range(1));
          push_escape($urandom, long_form, $urandom_range(long_form ? 7 : 3));
        end
        // cut short either by the end of the string or by a non-digit
        if ($urandom_range(2) == 0) begin
          end_string();
        end else begin
          do b = 8'($urandom_range(255)); while (hex_nibble(b) >= 0);
          push_byte(b, 1'b0);
        end
      end else begin
        repeat ($urandom_range(4, 1)) push_byte(8'($urandom_range(255)), 1'b0);
      end
      if ($urandom_range(9) == 0) end_string();
    end
    end_string();
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued words, predicts on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_byte  <= 8'h00;
      in_last  <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) decode_byte(in_byte, in_last);
      if (!in_valid || in_ready_o) begin
        if (bytes_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          next_word = bytes_to_send.pop_front();
          in_byte  <= next_word.data;
          in_last  <= next_word.last;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Long hold-off in the last phase so the core backs up and stalls its input
  initial begin
    while (tb_phase != 3) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HoldOffCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Monitor: every accepted word against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      if (utf8_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected word: data %02h valid %0b run_last %0b end %0b",
                                  out_byte_o, byte_valid_o, run_last_o, string_end_o));
      end else begin
        want_word = utf8_expected.pop_front();
        if (out_byte_o !== want_word.data)
          report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte_o, want_word.data));
        if (byte_valid_o !== want_word.data_valid)
          report_mismatch($sformatf("byte_valid %0b, expected %0b",
                                    byte_valid_o, want_word.data_valid));
        if (run_last_o !== want_word.run_last)
          report_mismatch($sformatf("run_last %0b, expected %0b",
                                    run_last_o, want_word.run_last));
        if (string_end_o !== want_word.string_end)
          report_mismatch($sformatf("string_end %0b, expected %0b",
                                    string_end_o, want_word.string_end));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of phases
  // ---------------------------------------------------------------------------
  initial begin
    foreach (held_q[i]) held_q[i] = 8'h00;

    // directed: byte extremes, zero escape, stray backslash, broken escape
    // restarted by a backslash, end inside an escape, dropped surrogate as empty end
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_escape(32'h0, 1'b0, 4);
    push_byte(CharBslash, 1'b0);
    push_byte(8'h71, 1'b0);
    push_escape(32'h1000, 1'b0, 1);
    push_byte(CharBslash, 1'b0);
    push_byte(CharLowU, 1'b1);
    push_escape(32'hDFFF, 1'b0, 4);
    end_string();
    fill_random(60);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_to_send.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    tx_idle_pct = 65;
    rx_idle_pct = 34;
    tb_phase = 2;
    fill_random(60);

    while (bytes_to_send.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    tb_phase = 3;
    fill_random(60);

    // drain
    while (bytes_to_send.size() != 0 || in_valid) @(posedge clk_i);
    while (utf8_expected.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(longint'(MaxCycles) * ClkPeriod);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/uesc_pkg.sv
rtl/uesc_dp.sv
rtl/uesc_ctrl.sv
rtl/unicode_escape_to_utf8_core.sv
bench/tb_top.sv
